/* src/cbcg_pkg.sv */
// ----------------------------------------------------------------------------
// cbcg_pkg
// Shared constants, register codes and widths for the bezier color gradient.
// ----------------------------------------------------------------------------
package cbcg_pkg;

  localparam int unsigned POS_W      = 16;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // fixed-point lerp: 16 fraction bits of the weight
  localparam int unsigned FRAC_W = 16;

  // rounding offsets; the negative one folds -32767 and the +65535 of a
  // toward-zero shift into one constant
  localparam logic [FRAC_W-1:0] RND_POS = 16'd32767;
  localparam logic [FRAC_W-1:0] RND_NEG = 16'd32768;

  // latency of one lerp and of one cubic curve
  localparam int unsigned LERP_LAT   = 2;
  localparam int unsigned BEZ_LAT    = 3 * LERP_LAT;
  localparam int unsigned PIPE_DEPTH = 2 * BEZ_LAT;

  localparam logic [COLOR_W-1:0] COLOR0_RST = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR1_RST = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR2_RST = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] COLOR3_RST = 24'hFFFFFF;
  localparam logic [POS_W-1:0]   BIAS0_RST  = 16'd21845;
  localparam logic [POS_W-1:0]   BIAS1_RST  = 16'd43690;
  localparam logic [POS_W-1:0]   POS_MAX    = 16'd65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR0      = 3'd0,
    REG_COLOR1      = 3'd1,
    REG_COLOR2      = 3'd2,
    REG_COLOR3      = 3'd3,
    REG_BIAS_FIRST  = 3'd4,
    REG_BIAS_SECOND = 3'd5
  } cfg_reg_e;

endpackage

/* src/cbcg_lerp.sv */
// ----------------------------------------------------------------------------
// cbcg_lerp
// Two-stage fixed-point lerp: difference times weight, then round and add.
// ----------------------------------------------------------------------------
module cbcg_lerp #(
  parameter int unsigned W = cbcg_pkg::CH_W
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [W-1:0]                a_i,
  input  logic [W-1:0]                b_i,
  input  logic [cbcg_pkg::POS_W-1:0]  t_i,
  output logic [W-1:0]                y_o
);

  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = W + cbcg_pkg::POS_W + 2;
  localparam int unsigned AW = PW + 1;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod_d, prod_q;
  logic                 lt_d, lt_q;
  logic [W-1:0]         a_q;
  logic signed [AW-1:0] acc;
  logic [W-1:0]         y_d, y_q;

  assign diff   = $signed({1'b0, b_i}) - $signed({1'b0, a_i});
  assign prod_d = PW'(diff) * PW'($signed({1'b0, t_i}));
  assign lt_d   = (a_i < b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
      lt_q   <= lt_d;
    end
  end

  // sign of the product is known from lt, so one offset gives toward-zero
  assign acc = AW'(prod_q) + $signed({{(AW-cbcg_pkg::FRAC_W){1'b0}},
                                     (lt_q ? cbcg_pkg::RND_POS : cbcg_pkg::RND_NEG)});
  assign y_d = a_q + acc[cbcg_pkg::FRAC_W+W-1:cbcg_pkg::FRAC_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

/* src/cbcg_bezier.sv */
// ----------------------------------------------------------------------------
// cbcg_bezier
// Cubic de Casteljau curve as three lerp levels, weight delayed alongside.
// ----------------------------------------------------------------------------
module cbcg_bezier #(
  parameter int unsigned W = cbcg_pkg::CH_W
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [W-1:0]                p0_i,
  input  logic [W-1:0]                p1_i,
  input  logic [W-1:0]                p2_i,
  input  logic [W-1:0]                p3_i,
  input  logic [cbcg_pkg::POS_W-1:0]  t_i,
  output logic [W-1:0]                y_o
);

  logic [cbcg_pkg::POS_W-1:0] t1_q [cbcg_pkg::LERP_LAT];
  logic [cbcg_pkg::POS_W-1:0] t2_q [cbcg_pkg::LERP_LAT];
  logic [W-1:0] ab, bc, cd, abc, bcd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q[0] <= t_i;
      t2_q[0] <= t1_q[cbcg_pkg::LERP_LAT-1];
      for (int i = 1; i < cbcg_pkg::LERP_LAT; i++) begin
        t1_q[i] <= t1_q[i-1];
        t2_q[i] <= t2_q[i-1];
      end
    end
  end

  cbcg_lerp #(.W(W)) u_ab (.clk_i, .en_i, .a_i(p0_i), .b_i(p1_i), .t_i(t_i), .y_o(ab));
  cbcg_lerp #(.W(W)) u_bc (.clk_i, .en_i, .a_i(p1_i), .b_i(p2_i), .t_i(t_i), .y_o(bc));
  cbcg_lerp #(.W(W)) u_cd (.clk_i, .en_i, .a_i(p2_i), .b_i(p3_i), .t_i(t_i), .y_o(cd));

  cbcg_lerp #(.W(W)) u_abc (.clk_i, .en_i, .a_i(ab), .b_i(bc),
                            .t_i(t1_q[cbcg_pkg::LERP_LAT-1]), .y_o(abc));
  cbcg_lerp #(.W(W)) u_bcd (.clk_i, .en_i, .a_i(bc), .b_i(cd),
                            .t_i(t1_q[cbcg_pkg::LERP_LAT-1]), .y_o(bcd));

  cbcg_lerp #(.W(W)) u_out (.clk_i, .en_i, .a_i(abc), .b_i(bcd),
                            .t_i(t2_q[cbcg_pkg::LERP_LAT-1]), .y_o(y_o));

endmodule

/* src/cubic_bezier_color_gradient_unit.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_color_gradient_unit
// Position bias curve followed by three per-channel cubic bezier curves.
// ----------------------------------------------------------------------------
// pipeline: 6 lerp levels from accepted position to valid color, each a
//   multiply stage and a round/add stage
// throughput: one word per cycle; the whole pipeline holds while the output
//   word waits, so ready is low only when the last stage is full and stalled
// reset: asynchronous, clears the stage valid bits and loads register defaults
module cubic_bezier_color_gradient_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cbcg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cbcg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cbcg_pkg::POS_W-1:0]       position_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cbcg_pkg::CH_W-1:0]        red_o,
  output logic [cbcg_pkg::CH_W-1:0]        green_o,
  output logic [cbcg_pkg::CH_W-1:0]        blue_o
);

  logic [cbcg_pkg::COLOR_W-1:0] color0_q, color1_q, color2_q, color3_q;
  logic [cbcg_pkg::POS_W-1:0]   bias0_q, bias1_q;
  logic [cbcg_pkg::PIPE_DEPTH-1:0] vld_q;
  logic                         en;
  logic [cbcg_pkg::POS_W-1:0]   warped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color0_q <= cbcg_pkg::COLOR0_RST;
      color1_q <= cbcg_pkg::COLOR1_RST;
      color2_q <= cbcg_pkg::COLOR2_RST;
      color3_q <= cbcg_pkg::COLOR3_RST;
      bias0_q  <= cbcg_pkg::BIAS0_RST;
      bias1_q  <= cbcg_pkg::BIAS1_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbcg_pkg::REG_COLOR0:      color0_q <= cfg_data_i;
        cbcg_pkg::REG_COLOR1:      color1_q <= cfg_data_i;
        cbcg_pkg::REG_COLOR2:      color2_q <= cfg_data_i;
        cbcg_pkg::REG_COLOR3:      color3_q <= cfg_data_i;
        cbcg_pkg::REG_BIAS_FIRST:  bias0_q  <= cfg_data_i[cbcg_pkg::POS_W-1:0];
        cbcg_pkg::REG_BIAS_SECOND: bias1_q  <= cfg_data_i[cbcg_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // global stage enable: advance unless the last word is held
  assign en         = !vld_q[cbcg_pkg::PIPE_DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[cbcg_pkg::PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  cbcg_bezier #(.W(cbcg_pkg::POS_W)) u_bias (
    .clk_i, .en_i(en),
    .p0_i('0), .p1_i(bias0_q), .p2_i(bias1_q), .p3_i(cbcg_pkg::POS_MAX),
    .t_i(position_i), .y_o(warped)
  );

  cbcg_bezier #(.W(cbcg_pkg::CH_W)) u_red (
    .clk_i, .en_i(en),
    .p0_i(color0_q[23:16]), .p1_i(color1_q[23:16]),
    .p2_i(color2_q[23:16]), .p3_i(color3_q[23:16]),
    .t_i(warped), .y_o(red_o)
  );

  cbcg_bezier #(.W(cbcg_pkg::CH_W)) u_green (
    .clk_i, .en_i(en),
    .p0_i(color0_q[15:8]), .p1_i(color1_q[15:8]),
    .p2_i(color2_q[15:8]), .p3_i(color3_q[15:8]),
    .t_i(warped), .y_o(green_o)
  );

  cbcg_bezier #(.W(cbcg_pkg::CH_W)) u_blue (
    .clk_i, .en_i(en),
    .p0_i(color0_q[7:0]), .p1_i(color1_q[7:0]),
    .p2_i(color2_q[7:0]), .p3_i(color3_q[7:0]),
    .t_i(warped), .y_o(blue_o)
  );

  assign out_valid_o = vld_q[cbcg_pkg::PIPE_DEPTH-1];

endmodule

/* src/cbcg_checker.sv */
// ----------------------------------------------------------------------------
// cbcg_checker
// Port-level checks of the gradient unit, bound to the top level.
// ----------------------------------------------------------------------------
module cbcg_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [cbcg_pkg::CH_W-1:0]  red_o,
  input logic [cbcg_pkg::CH_W-1:0]  green_o,
  input logic [cbcg_pkg::CH_W-1:0]  blue_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o)
      && $stable(green_o) && $stable(blue_o))
    else $error("output word changed while stalled");

  // an empty output stage never blocks the input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output stage");

  // a taken output frees the pipeline in the same cycle
  a_taken_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output taken");

endmodule

bind cubic_bezier_color_gradient_unit cbcg_checker u_cbcg_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .red_o, .green_o, .blue_o
);

/* tb/sv/tb_cubic_bezier_color_gradient_unit.sv */
// ----------------------------------------------------------------------------
// tb_cubic_bezier_color_gradient_unit
// Streams positions through the gradient unit under random gaps and output
// stalls and checks each color word against a local de Casteljau predictor.
// Register settings change between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_color_gradient_unit;

  import cbcg_pkg::*;

  localparam longint LERP_RND    = 32767;
  localparam longint LERP_DIV    = 65536;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     RAND_PHASES = 14;
  localparam int     PHASE_ITEMS = 100;

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [POS_W-1:0]      position_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CH_W-1:0]       red_o;
  logic [CH_W-1:0]       green_o;
  logic [CH_W-1:0]       blue_o;

  // shadow copy of the register file
  logic [COLOR_W-1:0] shadow_color [4];
  logic [POS_W-1:0]   shadow_bias_first;
  logic [POS_W-1:0]   shadow_bias_second;

  logic [POS_W-1:0] positions_pending [$];
  rgb_t             colors_expected [$];

  bit gaps_on     = 1'b1;
  int fail_count  = 0;
  int cycle_count = 0;

  cubic_bezier_color_gradient_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  always #5 clk_i = ~clk_i;

  // signed division truncates toward zero, as the lerp wants
  function automatic longint lerp_fixed(longint a, longint b, longint t);
    longint acc;
    acc = (b - a) * t;
    acc += (a < b) ? LERP_RND : -LERP_RND;
    acc = acc / LERP_DIV;
    return acc + a;
  endfunction

  function automatic longint bezier_cubic(longint a, longint b, longint c, longint d,
                                          longint t);
    longint ab, bc, cd, abc, bcd;
    ab  = lerp_fixed(a, b, t);
    bc  = lerp_fixed(b, c, t);
    cd  = lerp_fixed(c, d, t);
    abc = lerp_fixed(ab, bc, t);
    bcd = lerp_fixed(bc, cd, t);
    return lerp_fixed(abc, bcd, t);
  endfunction

  function automatic rgb_t gradient_color(logic [POS_W-1:0] pos);
    longint          warped;
    longint          level;
    logic [POS_W-1:0] wt;
    logic [CH_W-1:0] chan [3];
    int              sh;
    warped = bezier_cubic(0, longint'(shadow_bias_first), longint'(shadow_bias_second),
                          longint'(POS_MAX), longint'(pos));
    wt = warped[POS_W-1:0];
    for (int k = 0; k < 3; k++) begin
      sh = 16 - 8 * k;
      level = bezier_cubic(longint'(shadow_color[0][sh +: 8]),
                           longint'(shadow_color[1][sh +: 8]),
                           longint'(shadow_color[2][sh +: 8]),
                           longint'(shadow_color[3][sh +: 8]), longint'(wt));
      chan[k] = level[CH_W-1:0];
    end
    return '{red: chan[0], green: chan[1], blue: chan[2]};
  endfunction

  function automatic bit stall_now();
    return gaps_on && ($urandom_range(0, 99) < 9);
  endfunction

  // position driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      position_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        colors_expected.push_back(gradient_color(position_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (positions_pending.size() != 0 && !stall_now()) begin
          in_valid_i <= 1'b1;
          position_i <= positions_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // color word monitor
  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (colors_expected.size() == 0) begin
          $display("%0t: color word with nothing expected: r=%h g=%h b=%h",
                   $time, red_o, green_o, blue_o);
          fail_count++;
        end else begin
          want = colors_expected.pop_front();
          if (red_o !== want.red) begin
            $display("%0t: red mismatch: expected %h actual %h", $time, want.red, red_o);
            fail_count++;
          end
          if (green_o !== want.green) begin
            $display("%0t: green mismatch: expected %h actual %h",
                     $time, want.green, green_o);
            fail_count++;
          end
          if (blue_o !== want.blue) begin
            $display("%0t: blue mismatch: expected %h actual %h", $time, want.blue, blue_o);
            fail_count++;
          end
        end
      end
      out_ready_i <= !stall_now();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_COLOR0:      shadow_color[0]    = data;
      REG_COLOR1:      shadow_color[1]    = data;
      REG_COLOR2:      shadow_color[2]    = data;
      REG_COLOR3:      shadow_color[3]    = data;
      REG_BIAS_FIRST:  shadow_bias_first  = data[POS_W-1:0];
      REG_BIAS_SECOND: shadow_bias_second = data[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reg_write_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // bias writes carry junk in the upper byte, the register keeps 16 bits
  task automatic bias_write(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] bias);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[POS_W-1:0] = bias;
    reg_write(idx, data);
  endtask

  task automatic wait_drained();
    while (positions_pending.size() != 0 || in_valid_i || colors_expected.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic push_corner_positions();
    positions_pending.push_back(16'h0000);
    positions_pending.push_back(16'h8000);
    positions_pending.push_back(16'h5555);
    positions_pending.push_back(16'hFFFF);
  endtask

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_bias();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_position();
    case ($urandom_range(0, 19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      3:       return 16'hFFFE;
      4:       return 16'h7FFF;
      5:       return 16'h8000;
      default: return POS_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [COLOR_W-1:0] flat;
    shadow_color[0]    = COLOR0_RST;
    shadow_color[1]    = COLOR1_RST;
    shadow_color[2]    = COLOR2_RST;
    shadow_color[3]    = COLOR3_RST;
    shadow_bias_first  = BIAS0_RST;
    shadow_bias_second = BIAS1_RST;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values, ascending curves
    push_corner_positions();
    positions_pending.push_back(16'h0001);
    positions_pending.push_back(16'h7FFF);
    positions_pending.push_back(16'hAAAA);
    positions_pending.push_back(16'hFFFE);
    wait_drained();

    // everything at maximum, spare indexes must not disturb it
    reg_write(REG_COLOR0, '1);
    reg_write(REG_COLOR1, '1);
    reg_write(REG_COLOR2, '1);
    reg_write(REG_COLOR3, '1);
    reg_write(REG_BIAS_FIRST, '1);
    reg_write(REG_BIAS_SECOND, '1);
    reg_write(IDX_SPARE_A, CFG_DATA_W'($urandom));
    reg_write(IDX_SPARE_B, CFG_DATA_W'($urandom));
    reg_write_done();
    push_corner_positions();
    wait_drained();

    // everything at zero
    reg_write(REG_COLOR0, '0);
    reg_write(REG_COLOR1, '0);
    reg_write(REG_COLOR2, '0);
    reg_write(REG_COLOR3, '0);
    bias_write(REG_BIAS_FIRST, '0);
    bias_write(REG_BIAS_SECOND, '0);
    reg_write_done();
    push_corner_positions();
    wait_drained();

    // equal control points on every color channel, both bias points equal
    flat = COLOR_W'($urandom);
    reg_write(REG_COLOR0, flat);
    reg_write(REG_COLOR1, flat);
    reg_write(REG_COLOR2, flat);
    reg_write(REG_COLOR3, flat);
    flat = COLOR_W'($urandom);
    bias_write(REG_BIAS_FIRST, flat[POS_W-1:0]);
    bias_write(REG_BIAS_SECOND, flat[POS_W-1:0]);
    reg_write_done();
    push_corner_positions();
    wait_drained();

    // descending color curves take the negative rounding offset
    reg_write(REG_COLOR0, '1);
    reg_write(REG_COLOR1, CFG_DATA_W'($urandom));
    reg_write(REG_COLOR2, CFG_DATA_W'($urandom));
    reg_write(REG_COLOR3, '0);
    bias_write(REG_BIAS_FIRST, '1);
    bias_write(REG_BIAS_SECOND, '0);
    reg_write_done();
    push_corner_positions();
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      reg_write(REG_COLOR0, rand_color());
      reg_write(REG_COLOR1, rand_color());
      reg_write(REG_COLOR2, rand_color());
      reg_write(REG_COLOR3, rand_color());
      bias_write(REG_BIAS_FIRST, rand_bias());
      bias_write(REG_BIAS_SECOND, rand_bias());
      if ($urandom_range(0, 2) == 0) begin
        reg_write($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B,
                  CFG_DATA_W'($urandom));
      end
      reg_write_done();
      // one phase runs back to back on both sides
      gaps_on = (ph != RAND_PHASES / 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        positions_pending.push_back(rand_position());
      end
      wait_drained();
      gaps_on = 1'b1;
    end

    if (fail_count == 0 && colors_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
